### sv/acs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types, constants and helpers of the accumulator CPU step block.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int MEMORY_WORDS = 256;
  localparam int WORD_BITS    = 32;
  localparam int ADDR_W       = $clog2(MEMORY_WORDS);

  localparam int MODE_W    = 2;
  localparam int IN_ADDR_W = 8;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int PC_W      = 8;
  localparam int IDX_DEPTH = 1 << IN_ADDR_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_EXEC  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_HALT = 2'd1,
    STAT_BAD  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_NOP = 4'h0,
    OP_LDA = 4'h1,
    OP_STA = 4'h2,
    OP_ADD = 4'h3,
    OP_SUB = 4'h4,
    OP_JMP = 4'h5,
    OP_JZ  = 4'h6,
    OP_JN  = 4'h7,
    OP_HLT = 4'h8
  } opcode_e;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [ADDR_W-1:0]    raddr;
  } mem_req_t;

  typedef logic [ADDR_W-1:0] idx_tab_t [IDX_DEPTH];

  // external address folded onto the memory depth
  function automatic idx_tab_t mk_idx_tab();
    idx_tab_t t;
    for (int i = 0; i < IDX_DEPTH; i++) begin
      t[i] = ADDR_W'(i % MEMORY_WORDS);
    end
    return t;
  endfunction

  localparam idx_tab_t IDX_TAB = mk_idx_tab();

  function automatic logic [WORD_BITS-1:0] sext_word(logic signed [DATA_W-1:0] d);
    logic [63:0] w;
    w = {{(64-DATA_W){d[DATA_W-1]}}, d};
    return w[WORD_BITS-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] low_data(logic [WORD_BITS-1:0] w);
    logic [63:0] x;
    x = 64'(w);
    return x[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

### sv/acs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acs_in_if / acs_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface acs_in_if import acs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [IN_ADDR_W-1:0]     address;
  logic signed [DATA_W-1:0] data;

  modport source (output valid, output mode, output address, output data, input ready);
  modport sink   (input valid, input mode, input address, input data, output ready);
endinterface

interface acs_out_if import acs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] accumulator;
  logic [PC_W-1:0]          program_counter;
  logic signed [DATA_W-1:0] read_data;

  modport source (output valid, output status, output accumulator, output program_counter,
                  output read_data, input ready);
  modport sink   (input valid, input status, input accumulator, input program_counter,
                  input read_data, output ready);
endinterface
`default_nettype wire

### sv/acs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module acs_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### sv/acs_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acs_mem
// Main memory: RAM plus per-word written flags; unwritten words read as zero.
// ----------------------------------------------------------------------------
module acs_mem import acs_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mem_req_t             req_i,
  output logic     [WORD_BITS-1:0]  rdata_o
);

  logic [MEMORY_WORDS-1:0] valid_q;
  logic                    rd_valid_q;
  logic [WORD_BITS-1:0]    ram_rdata;

  acs_ram #(
    .Width (WORD_BITS),
    .Depth (MEMORY_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.we),
    .waddr_i (req_i.waddr),
    .wdata_i (req_i.wdata),
    .re_i    (req_i.re),
    .raddr_i (req_i.raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rd_valid_q ? ram_rdata : '0;

endmodule
`default_nettype wire

### sv/accumulator_cpu_step_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// accumulator_cpu_step_top
// Accumulator processor stepped one command at a time over a word memory.
//
// Commands arrive on in_i (write word, execute one instruction, read word);
// each gives exactly one result on out_o with status, accumulator, program
// counter and read data. Memory words sit in one RAM with registered read.
// Steps from command transfer to result valid:
//   write word / unused mode : acknowledge
//   read word                : one RAM read
//   NOP, STA, jumps, HLT, bad: instruction fetch
//   LDA, ADD, SUB            : fetch, then operand read
// The next command is taken in the cycle the current result is registered,
// except after STA: the block first returns to idle because the RAM write
// port is busy with the store.
// The output register holds a result while out_o.ready is low; the block
// then stops taking commands and holds its sequence. Reset clears the
// accumulator, the program counter and the per-word written flags, so the
// whole memory reads zero right after reset with no clearing pass.
// ----------------------------------------------------------------------------
module accumulator_cpu_step_top import acs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  acs_in_if.sink    in_i,
  acs_out_if.source out_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACK   = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_OPND  = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [ADDR_W-1:0]    pc_q, pc_d, pc_inc;
  opcode_e              op_q, op_d;

  logic                 out_valid_q, out_valid_d;
  status_e              st_q, st_d;
  logic [DATA_W-1:0]    out_acc_q;
  logic [PC_W-1:0]      out_pc_q;
  logic [DATA_W-1:0]    rd_q, rd_d;

  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] mem_rdata;
  opcode_e              word_op;
  logic [3:0]           word_arg;

  logic out_free, fin, fin_wr, fire, in_ready, in_xfer;

  acs_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign word_op  = opcode_e'(mem_rdata[7:4]);
  assign word_arg = mem_rdata[3:0];
  assign pc_inc   = (pc_q == ADDR_W'(MEMORY_WORDS - 1)) ? '0 : pc_q + ADDR_W'(1);

  always_comb begin
    state_d  = state_q;
    acc_d    = acc_q;
    pc_d     = pc_q;
    op_d     = op_q;
    mem_req  = '0;
    fin      = 1'b0;
    fin_wr   = 1'b0;
    st_d     = STAT_OK;
    rd_d     = '0;
    in_ready = 1'b0;
    in_xfer  = 1'b0;

    case (state_q)
      S_IDLE: begin
      end
      S_ACK: begin
        fin = 1'b1;
      end
      S_RD: begin
        fin  = 1'b1;
        rd_d = low_data(mem_rdata);
      end
      S_FETCH: begin
        pc_d = pc_inc;
        fin  = 1'b1;
        case (word_op)
          OP_LDA, OP_ADD, OP_SUB: begin
            fin           = 1'b0;
            mem_req.re    = 1'b1;
            mem_req.raddr = ADDR_W'(word_arg);
            op_d          = word_op;
            state_d       = S_OPND;
          end
          OP_STA: begin
            fin_wr        = 1'b1;
            mem_req.we    = out_free;
            mem_req.waddr = ADDR_W'(word_arg);
            mem_req.wdata = acc_q;
          end
          OP_NOP: begin
          end
          OP_JMP: pc_d = ADDR_W'(word_arg);
          OP_JZ: begin
            if (acc_q == '0) begin
              pc_d = ADDR_W'(word_arg);
            end
          end
          OP_JN: begin
            if (acc_q[WORD_BITS-1]) begin
              pc_d = ADDR_W'(word_arg);
            end
          end
          OP_HLT:  st_d = STAT_HALT;
          default: st_d = STAT_BAD;
        endcase
      end
      S_OPND: begin
        fin = 1'b1;
        case (op_q)
          OP_LDA:  acc_d = mem_rdata;
          OP_ADD:  acc_d = acc_q + mem_rdata;
          OP_SUB:  acc_d = acc_q - mem_rdata;
          default: acc_d = acc_q;
        endcase
      end
      default: state_d = S_IDLE;
    endcase

    fire = fin && out_free;
    if (fin && !out_free) begin
      state_d = state_q;
      pc_d    = pc_q;
      acc_d   = acc_q;
    end else if (fin) begin
      state_d = S_IDLE;
    end

    // no new command while a store owns the write port
    in_ready = out_free && ((state_q == S_IDLE) || (fin && !fin_wr));
    in_xfer  = in_i.valid && in_ready;

    if (in_xfer) begin
      case (mode_e'(in_i.mode))
        MODE_WRITE: begin
          mem_req.we    = 1'b1;
          mem_req.waddr = IDX_TAB[in_i.address];
          mem_req.wdata = sext_word(in_i.data);
          state_d       = S_ACK;
        end
        MODE_EXEC: begin
          mem_req.re    = 1'b1;
          mem_req.raddr = pc_d;
          state_d       = S_FETCH;
        end
        MODE_READ: begin
          mem_req.re    = 1'b1;
          mem_req.raddr = IDX_TAB[in_i.address];
          state_d       = S_RD;
        end
        default: state_d = S_ACK;
      endcase
    end

    out_valid_d = fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    if (fire) begin
      st_q      <= st_d;
      out_acc_q <= low_data(acc_d);
      out_pc_q  <= PC_W'(pc_d);
      rd_q      <= rd_d;
    end
  end

  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_valid_q;
  assign out_o.status          = st_q;
  assign out_o.accumulator     = out_acc_q;
  assign out_o.program_counter = out_pc_q;
  assign out_o.read_data       = rd_q;

`ifndef NO_ASSERTIONS
  a_sta_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH && fin_wr) |-> !in_i.ready)
    else $error("command taken while store writes memory");

  a_single_port_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("memory read and write in the same cycle");

  a_exec_fetches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.mode == MODE_EXEC) |=> (state_q == S_FETCH))
    else $error("execute transfer did not start a fetch");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) != S_IDLE))
    else $error("result appeared without a command in flight");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= ADDR_W'(MEMORY_WORDS - 1))
    else $error("program counter beyond memory");
`endif

endmodule
`default_nettype wire
